/* rtl/circumcircle_point_test_macros.svh */
// Assertion macros used by the checker file of the circumcircle point test.
`ifndef CIRCUMCIRCLE_POINT_TEST_MACROS_SVH
`define CIRCUMCIRCLE_POINT_TEST_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define CPT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define CPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that is also checked around reset.
`define CPT_ASSERT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/cpt_pkg.sv */
// Shared constants, types and helpers of the circumcircle point test.
package cpt_pkg;

    // Default geometry of the datapath.
    localparam int COORD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF   = 8;

    // Fixed widths of the result fields.
    localparam int CENTER_WIDTH    = 32;
    localparam int RAD_WIDTH       = 56;
    localparam int OUT_TDATA_WIDTH = 128;

    // Saturation limits of a centre coordinate.
    localparam logic [CENTER_WIDTH-1:0] CENTER_MAX = 32'h7FFF_FFFF;
    localparam logic [CENTER_WIDTH-1:0] CENTER_MIN = 32'h8000_0000;

    // Per-item status that travels alongside the wide datapath.
    typedef struct packed {
        logic valid;
        logic degenerate;
        logic in_circle;
        logic cx_neg;
        logic cy_neg;
    } cpt_flags_t;

    // Larger of two elaboration-time integers.
    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* rtl/circumcircle_point_test.sv */
// Top level of the circumcircle point test: front end, dividers and output buffer.
//
//  channel | direction | payload (low bits first)
//  s_      | in        | a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y
//  m_      | out       | center_x, center_y, radius_squared, inside_res, degenerate
//
// One request enters per cycle while the skid register is free. The pipeline depth is
// set by the radius divider, which resolves one quotient bit per stage.
// Reset is synchronous and clears the valid bits, the handshake state and the
// aligning delay lines.
// A result that is not taken goes to a one-entry skid register; the whole
// pipeline holds while that register is full, so nothing is lost or repeated.
module circumcircle_point_test #(
    parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = cpt_pkg::FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // vertex_a_x, vertex_a_y, vertex_b_x, vertex_b_y, vertex_c_x, vertex_c_y,
    // point_x, point_y
    input  logic [8*COORD_WIDTH-1:0]              s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // center_x, center_y, radius_squared, inside_res, degenerate, zero fill
    output logic [cpt_pkg::OUT_TDATA_WIDTH-1:0]   m_tdata
);

    localparam int W    = COORD_WIDTH;
    localparam int CW   = cpt_pkg::CENTER_WIDTH;
    localparam int QBC  = cpt_pkg::max_int(W + FRAC_BITS, CW) + 2;
    localparam int QBR  = cpt_pkg::RAD_WIDTH;
    localparam int NCN  = 3*W + 2 + FRAC_BITS;
    localparam int NWC  = cpt_pkg::max_int(NCN, QBC + 1);
    localparam int DWC  = 2*W + 2;
    localparam int NRN  = 6*W + 5 + FRAC_BITS;
    localparam int NWR  = cpt_pkg::max_int(NRN, QBR + 1);
    localparam int DWR  = 4*W + 4;
    localparam int SUMW = QBC + 3;
    localparam int SBW  = $bits(cpt_pkg::cpt_flags_t) + 2*W;
    localparam int PADW = cpt_pkg::OUT_TDATA_WIDTH - 2*CW - QBR - 2;

    logic en;

    cpt_pkg::cpt_flags_t     fr_flags;
    logic signed [W-1:0]     fr_ax, fr_ay;
    logic [NCN-1:0]          fr_num_cx, fr_num_cy;
    logic [DWC-1:0]          fr_den_c;
    logic [NRN-1:0]          fr_num_r;
    logic [DWR-1:0]          fr_den_r;

    logic [QBC-1:0]          quo_cx, quo_cy;
    logic                    rnz_cx, rnz_cy;
    logic [QBR-1:0]          quo_r;
    logic                    rnz_r;

    logic [SBW-1:0]          sb_q;
    cpt_pkg::cpt_flags_t     d_flags;
    logic signed [W-1:0]     d_ax, d_ay;
    logic [2*QBC+1:0]        cq_q;
    logic [QBC-1:0]          d_quo_cx, d_quo_cy;
    logic                    d_rnz_cx, d_rnz_cy;

    logic [SUMW-1:0]         qext_x, qext_y;
    logic signed [SUMW-1:0]  aext_x, aext_y, csum_x, csum_y;
    logic                    ovf_x, ovf_y;
    logic [CW-1:0]           cx_sat, cy_sat;
    logic [cpt_pkg::OUT_TDATA_WIDTH-1:0] fin_next;

    logic                    fin_valid_reg;
    logic [cpt_pkg::OUT_TDATA_WIDTH-1:0] fin_data_reg;
    logic                    m_tvalid_reg;
    logic [cpt_pkg::OUT_TDATA_WIDTH-1:0] m_tdata_reg;
    logic                    skid_valid_reg;
    logic [cpt_pkg::OUT_TDATA_WIDTH-1:0] skid_data_reg;

    // The pipeline advances whenever the skid register is free.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    cpt_front #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .flags_o  (fr_flags),
        .ax_o     (fr_ax),
        .ay_o     (fr_ay),
        .num_cx_o (fr_num_cx),
        .num_cy_o (fr_num_cy),
        .den_c_o  (fr_den_c),
        .num_r_o  (fr_num_r),
        .den_r_o  (fr_den_r)
    );

    // Centre offsets: |N| * 2^F / (2 |ap|).
    cpt_div #(.NUM_WIDTH(NWC), .DEN_WIDTH(DWC), .QUO_WIDTH(QBC)) u_div_cx (
        .aclk     (aclk),
        .en       (en),
        .num_i    (NWC'(fr_num_cx)),
        .den_i    (fr_den_c),
        .quo_o    (quo_cx),
        .rem_nz_o (rnz_cx)
    );

    cpt_div #(.NUM_WIDTH(NWC), .DEN_WIDTH(DWC), .QUO_WIDTH(QBC)) u_div_cy (
        .aclk     (aclk),
        .en       (en),
        .num_i    (NWC'(fr_num_cy)),
        .den_i    (fr_den_c),
        .quo_o    (quo_cy),
        .rem_nz_o (rnz_cy)
    );

    // Squared radius: (Nx^2 + Ny^2) * 2^F / (4 ap^2).
    cpt_div #(.NUM_WIDTH(NWR), .DEN_WIDTH(DWR), .QUO_WIDTH(QBR)) u_div_r (
        .aclk     (aclk),
        .en       (en),
        .num_i    (NWR'(fr_num_r)),
        .den_i    (fr_den_r),
        .quo_o    (quo_r),
        .rem_nz_o (rnz_r)
    );

    // Flags and vertex a wait for the radius divider.
    cpt_delay #(.WIDTH(SBW), .DEPTH(QBR + 1)) u_dly_side (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d_i     ({fr_flags, fr_ax, fr_ay}),
        .q_o     (sb_q)
    );

    // The shorter centre dividers are padded to the same latency.
    cpt_delay #(.WIDTH(2*QBC + 2), .DEPTH(QBR - QBC)) u_dly_center (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .d_i     ({quo_cx, rnz_cx, quo_cy, rnz_cy}),
        .q_o     (cq_q)
    );

    assign {d_flags, d_ax, d_ay}                  = sb_q;
    assign {d_quo_cx, d_rnz_cx, d_quo_cy, d_rnz_cy} = cq_q;

    // Floored signed offset plus a * 2^F, then saturation to 32 bits.
    always_comb begin
        qext_x = SUMW'(d_quo_cx) + SUMW'(d_rnz_cx && d_flags.cx_neg);
        qext_y = SUMW'(d_quo_cy) + SUMW'(d_rnz_cy && d_flags.cy_neg);
        aext_x = SUMW'(d_ax);
        aext_y = SUMW'(d_ay);
        csum_x = $signed(d_flags.cx_neg ? -qext_x : qext_x) + (aext_x <<< FRAC_BITS);
        csum_y = $signed(d_flags.cy_neg ? -qext_y : qext_y) + (aext_y <<< FRAC_BITS);
        ovf_x  = !((&csum_x[SUMW-1:CW-1]) || !(|csum_x[SUMW-1:CW-1]));
        ovf_y  = !((&csum_y[SUMW-1:CW-1]) || !(|csum_y[SUMW-1:CW-1]));
        cx_sat = ovf_x ? (csum_x[SUMW-1] ? cpt_pkg::CENTER_MIN : cpt_pkg::CENTER_MAX)
                       : csum_x[CW-1:0];
        cy_sat = ovf_y ? (csum_y[SUMW-1] ? cpt_pkg::CENTER_MIN : cpt_pkg::CENTER_MAX)
                       : csum_y[CW-1:0];
        if (d_flags.degenerate) begin
            fin_next = {{PADW{1'b0}}, 1'b1, 1'b0, {QBR{1'b0}}, {(2*CW){1'b0}}};
        end else begin
            fin_next = {{PADW{1'b0}}, 1'b0, d_flags.in_circle, quo_r, cy_sat, cx_sat};
        end
    end

    // Final result stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= d_flags.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_data_reg <= fin_next;
        end
    end

    // Output register with skid: a blocked result parks in the skid register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_tready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= fin_valid_reg;
        end else if (fin_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_tready) begin
                m_tdata_reg <= skid_data_reg;
            end
        end else if (!m_tvalid_reg || m_tready) begin
            m_tdata_reg <= fin_data_reg;
        end else begin
            skid_data_reg <= fin_data_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Residue of the radius quotient is not needed: the radius is never negative.
    logic unused_rnz;
    assign unused_rnz = rnz_r;

endmodule

/* rtl/cpt_delay.sv */
// Enable-gated delay line used to align side information with the dividers.
module cpt_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [WIDTH-1:0] d_i,
    output logic [WIDTH-1:0] q_o
);

    logic [WIDTH-1:0] tap_reg [0:DEPTH-1];

    // Shift one place on every pipeline advance.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                tap_reg[i] <= '0;
            end
        end else if (en) begin
            tap_reg[0] <= d_i;
            for (int i = 1; i < DEPTH; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q_o = tap_reg[DEPTH-1];

endmodule

/* rtl/cpt_div.sv */
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
module cpt_div #(
    parameter int NUM_WIDTH = 64,
    parameter int DEN_WIDTH = 32,
    parameter int QUO_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [NUM_WIDTH-1:0] num_i,
    input  logic [DEN_WIDTH-1:0] den_i,
    output logic [QUO_WIDTH-1:0] quo_o,
    output logic                 rem_nz_o
);

    localparam int HI_WIDTH  = NUM_WIDTH - QUO_WIDTH;
    localparam int CMP_WIDTH = cpt_pkg::max_int(HI_WIDTH, DEN_WIDTH);

    logic [DEN_WIDTH-1:0] rem_reg [0:QUO_WIDTH];
    logic [QUO_WIDTH-1:0] low_reg [0:QUO_WIDTH];
    logic [QUO_WIDTH-1:0] quo_reg [0:QUO_WIDTH];
    logic [DEN_WIDTH-1:0] den_reg [0:QUO_WIDTH];
    logic                 ovf_reg [0:QUO_WIDTH];

    logic [CMP_WIDTH-1:0] hi_ext;
    logic [CMP_WIDTH-1:0] den_ext;

    // Upper numerator bits at or above the divisor mean the quotient does not fit.
    always_comb begin
        hi_ext  = CMP_WIDTH'(num_i[NUM_WIDTH-1:QUO_WIDTH]);
        den_ext = CMP_WIDTH'(den_i);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= hi_ext[DEN_WIDTH-1:0];
            low_reg[0] <= num_i[QUO_WIDTH-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den_i;
            ovf_reg[0] <= (hi_ext >= den_ext);
        end
    end

    // One trial subtraction per stage.
    for (genvar k = 1; k <= QUO_WIDTH; k++) begin : g_step
        logic [DEN_WIDTH:0] trial;
        logic [DEN_WIDTH:0] diff;
        logic               fits;

        always_comb begin
            trial = {rem_reg[k-1], low_reg[k-1][QUO_WIDTH-1]};
            diff  = trial - {1'b0, den_reg[k-1]};
            fits  = (trial >= {1'b0, den_reg[k-1]});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= fits ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
                low_reg[k] <= {low_reg[k-1][QUO_WIDTH-2:0], 1'b0};
                quo_reg[k] <= {quo_reg[k-1][QUO_WIDTH-2:0], fits};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo_o    = ovf_reg[QUO_WIDTH] ? '1 : quo_reg[QUO_WIDTH];
    assign rem_nz_o = |rem_reg[QUO_WIDTH];

endmodule

/* rtl/cpt_front.sv */
// Nine-stage exact integer front end: determinants, numerators and in-circle sign.
module cpt_front #(
    parameter int COORD_WIDTH = cpt_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = cpt_pkg::FRAC_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic                                   in_valid,
    input  logic [8*COORD_WIDTH-1:0]               in_data,
    output cpt_pkg::cpt_flags_t                    flags_o,
    output logic signed [COORD_WIDTH-1:0]          ax_o,
    output logic signed [COORD_WIDTH-1:0]          ay_o,
    output logic [3*COORD_WIDTH+1+FRAC_BITS:0]     num_cx_o,
    output logic [3*COORD_WIDTH+1+FRAC_BITS:0]     num_cy_o,
    output logic [2*COORD_WIDTH+1:0]               den_c_o,
    output logic [6*COORD_WIDTH+4+FRAC_BITS:0]     num_r_o,
    output logic [4*COORD_WIDTH+3:0]               den_r_o
);

    localparam int W    = COORD_WIDTH;
    localparam int DW   = W + 1;          // relative coordinate
    localparam int PW   = 2*W + 2;        // squares, ap, |.|^2
    localparam int NXW  = 3*W + 3;        // Nx, Ny signed
    localparam int NXM  = 3*W + 2;        // |Nx|, |Ny|
    localparam int LO   = (NXM + 1) / 2;  // low half for split squaring
    localparam int HI   = NXM - LO;
    localparam int NLO  = (NXW + 1) / 2;  // low half of Nx for the dot product
    localparam int APM  = 2*W + 1;        // |ap|
    localparam int PXW  = 4*W + 4;        // Px*Nx, |P|^2*ap
    localparam int TW   = 4*W + 6;        // in-circle determinant
    localparam int NSQ  = 2*NXM;          // Nx^2
    localparam int NCW  = 3*W + 2 + FRAC_BITS;
    localparam int NRW  = NSQ + 1 + FRAC_BITS;

    logic [8:0] vld_reg;

    logic signed [W-1:0]  axin, ayin, bxin, byin, cxin, cyin, pxin, pyin;

    // Stage 1: coordinates relative to vertex a.
    logic signed [W-1:0]  ax1_reg, ay1_reg;
    logic signed [DW-1:0] bx1_reg, by1_reg, cx1_reg, cy1_reg, px1_reg, py1_reg;
    // Stage 2: products.
    logic signed [W-1:0]  ax2_reg, ay2_reg;
    logic signed [DW-1:0] bx2_reg, by2_reg, cx2_reg, cy2_reg, px2_reg, py2_reg;
    logic signed [PW-1:0] bxcy2_reg, bycx2_reg, bxbx2_reg, byby2_reg;
    logic signed [PW-1:0] cxcx2_reg, cycy2_reg, pxpx2_reg, pypy2_reg;
    // Stage 3: ap and squared lengths.
    logic signed [W-1:0]  ax3_reg, ay3_reg;
    logic signed [DW-1:0] bx3_reg, by3_reg, cx3_reg, cy3_reg, px3_reg, py3_reg;
    logic signed [PW-1:0] ap3_reg, b2_3_reg, c2_3_reg, p2_3_reg;
    // Stage 4: numerator products.
    logic signed [W-1:0]   ax4_reg, ay4_reg;
    logic signed [DW-1:0]  px4_reg, py4_reg;
    logic signed [PW-1:0]  ap4_reg, p2_4_reg;
    logic signed [NXW-1:0] cyb2_4_reg, byc2_4_reg, bxc2_4_reg, cxb2_4_reg;
    // Stage 5: Nx, Ny.
    logic signed [W-1:0]   ax5_reg, ay5_reg;
    logic signed [DW-1:0]  px5_reg, py5_reg;
    logic signed [PW-1:0]  ap5_reg, p2_5_reg;
    logic signed [NXW-1:0] nx5_reg, ny5_reg;
    // Stage 6: magnitudes and in-circle partial products.
    logic signed [W-1:0]   ax6_reg, ay6_reg;
    logic signed [PXW-1:0] pxnxl6_reg, pxnxh6_reg, pynyl6_reg, pynyh6_reg, p2ap6_reg;
    logic [NXM-1:0]        nxm6_reg, nym6_reg;
    logic [APM-1:0]        apm6_reg;
    logic                  degen6_reg, nxneg6_reg, nyneg6_reg, apneg6_reg;
    // Stage 7: partial squares and dot product.
    logic signed [W-1:0]   ax7_reg, ay7_reg;
    logic [2*LO-1:0]       xll7_reg, yll7_reg;
    logic [LO+HI-1:0]      xlh7_reg, ylh7_reg;
    logic [2*HI-1:0]       xhh7_reg, yhh7_reg;
    logic [2*APM-1:0]      apsq7_reg;
    logic signed [PXW:0]   dot7_reg;
    logic signed [PXW-1:0] p2ap7_reg;
    logic [NXM-1:0]        nxm7_reg, nym7_reg;
    logic [APM-1:0]        apm7_reg;
    logic                  degen7_reg, nxneg7_reg, nyneg7_reg, apneg7_reg;
    // Stage 8: full squares and determinant.
    logic signed [W-1:0]   ax8_reg, ay8_reg;
    logic [NSQ-1:0]        nx2_8_reg, ny2_8_reg;
    logic signed [TW-1:0]  t8_reg;
    logic [2*APM-1:0]      apsq8_reg;
    logic [NXM-1:0]        nxm8_reg, nym8_reg;
    logic [APM-1:0]        apm8_reg;
    logic                  degen8_reg, nxneg8_reg, nyneg8_reg, apneg8_reg;
    // Stage 9: sum of squares and flag decisions.
    logic signed [W-1:0]   ax9_reg, ay9_reg;
    logic [NSQ:0]          s9_reg;
    logic [2*APM-1:0]      apsq9_reg;
    logic [NXM-1:0]        nxm9_reg, nym9_reg;
    logic [APM-1:0]        apm9_reg;
    logic                  degen9_reg, in_circle9_reg, cxneg9_reg, cyneg9_reg;

    logic                  t8_le0, t8_ge0;

    // Unpack the request fields.
    always_comb begin
        axin = in_data[0*W +: W];
        ayin = in_data[1*W +: W];
        bxin = in_data[2*W +: W];
        byin = in_data[3*W +: W];
        cxin = in_data[4*W +: W];
        cyin = in_data[5*W +: W];
        pxin = in_data[6*W +: W];
        pyin = in_data[7*W +: W];
    end

    // Valid bits move with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[7:0], in_valid};
        end
    end

    // Stages 1 to 3.
    always_ff @(posedge aclk) begin
        if (en) begin
            ax1_reg <= axin;
            ay1_reg <= ayin;
            bx1_reg <= DW'(bxin) - DW'(axin);
            by1_reg <= DW'(byin) - DW'(ayin);
            cx1_reg <= DW'(cxin) - DW'(axin);
            cy1_reg <= DW'(cyin) - DW'(ayin);
            px1_reg <= DW'(pxin) - DW'(axin);
            py1_reg <= DW'(pyin) - DW'(ayin);

            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            bx2_reg   <= bx1_reg;
            by2_reg   <= by1_reg;
            cx2_reg   <= cx1_reg;
            cy2_reg   <= cy1_reg;
            px2_reg   <= px1_reg;
            py2_reg   <= py1_reg;
            bxcy2_reg <= PW'(bx1_reg) * PW'(cy1_reg);
            bycx2_reg <= PW'(by1_reg) * PW'(cx1_reg);
            bxbx2_reg <= PW'(bx1_reg) * PW'(bx1_reg);
            byby2_reg <= PW'(by1_reg) * PW'(by1_reg);
            cxcx2_reg <= PW'(cx1_reg) * PW'(cx1_reg);
            cycy2_reg <= PW'(cy1_reg) * PW'(cy1_reg);
            pxpx2_reg <= PW'(px1_reg) * PW'(px1_reg);
            pypy2_reg <= PW'(py1_reg) * PW'(py1_reg);

            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            bx3_reg  <= bx2_reg;
            by3_reg  <= by2_reg;
            cx3_reg  <= cx2_reg;
            cy3_reg  <= cy2_reg;
            px3_reg  <= px2_reg;
            py3_reg  <= py2_reg;
            ap3_reg  <= bxcy2_reg - bycx2_reg;
            b2_3_reg <= bxbx2_reg + byby2_reg;
            c2_3_reg <= cxcx2_reg + cycy2_reg;
            p2_3_reg <= pxpx2_reg + pypy2_reg;
        end
    end

    // Stages 4 to 6; Px*Nx and Py*Ny are formed from a signed upper half and
    // an unsigned lower half of the numerator.
    always_ff @(posedge aclk) begin
        if (en) begin
            ax4_reg    <= ax3_reg;
            ay4_reg    <= ay3_reg;
            px4_reg    <= px3_reg;
            py4_reg    <= py3_reg;
            ap4_reg    <= ap3_reg;
            p2_4_reg   <= p2_3_reg;
            cyb2_4_reg <= NXW'(cy3_reg) * NXW'(b2_3_reg);
            byc2_4_reg <= NXW'(by3_reg) * NXW'(c2_3_reg);
            bxc2_4_reg <= NXW'(bx3_reg) * NXW'(c2_3_reg);
            cxb2_4_reg <= NXW'(cx3_reg) * NXW'(b2_3_reg);

            ax5_reg  <= ax4_reg;
            ay5_reg  <= ay4_reg;
            px5_reg  <= px4_reg;
            py5_reg  <= py4_reg;
            ap5_reg  <= ap4_reg;
            p2_5_reg <= p2_4_reg;
            nx5_reg  <= cyb2_4_reg - byc2_4_reg;
            ny5_reg  <= bxc2_4_reg - cxb2_4_reg;

            ax6_reg    <= ax5_reg;
            ay6_reg    <= ay5_reg;
            pxnxl6_reg <= PXW'(px5_reg) * PXW'($signed({1'b0, nx5_reg[NLO-1:0]}));
            pxnxh6_reg <= PXW'(px5_reg) * PXW'($signed(nx5_reg[NXW-1:NLO]));
            pynyl6_reg <= PXW'(py5_reg) * PXW'($signed({1'b0, ny5_reg[NLO-1:0]}));
            pynyh6_reg <= PXW'(py5_reg) * PXW'($signed(ny5_reg[NXW-1:NLO]));
            p2ap6_reg  <= PXW'(p2_5_reg) * PXW'(ap5_reg);
            nxm6_reg   <= nx5_reg[NXW-1] ? NXM'(-nx5_reg) : NXM'(nx5_reg);
            nym6_reg   <= ny5_reg[NXW-1] ? NXM'(-ny5_reg) : NXM'(ny5_reg);
            apm6_reg   <= ap5_reg[PW-1] ? APM'(-ap5_reg) : APM'(ap5_reg);
            degen6_reg <= (ap5_reg == '0);
            nxneg6_reg <= nx5_reg[NXW-1];
            nyneg6_reg <= ny5_reg[NXW-1];
            apneg6_reg <= ap5_reg[PW-1];
        end
    end

    // Stages 7 and 8: Nx^2 and Ny^2 from half-width partial products.
    always_ff @(posedge aclk) begin
        if (en) begin
            ax7_reg    <= ax6_reg;
            ay7_reg    <= ay6_reg;
            xll7_reg   <= (2*LO)'(nxm6_reg[LO-1:0]) * (2*LO)'(nxm6_reg[LO-1:0]);
            xlh7_reg   <= (LO+HI)'(nxm6_reg[LO-1:0]) * (LO+HI)'(nxm6_reg[NXM-1:LO]);
            xhh7_reg   <= (2*HI)'(nxm6_reg[NXM-1:LO]) * (2*HI)'(nxm6_reg[NXM-1:LO]);
            yll7_reg   <= (2*LO)'(nym6_reg[LO-1:0]) * (2*LO)'(nym6_reg[LO-1:0]);
            ylh7_reg   <= (LO+HI)'(nym6_reg[LO-1:0]) * (LO+HI)'(nym6_reg[NXM-1:LO]);
            yhh7_reg   <= (2*HI)'(nym6_reg[NXM-1:LO]) * (2*HI)'(nym6_reg[NXM-1:LO]);
            apsq7_reg  <= (2*APM)'(apm6_reg) * (2*APM)'(apm6_reg);
            dot7_reg   <= ((PXW+1)'(pxnxh6_reg) <<< NLO) + (PXW+1)'(pxnxl6_reg)
                          + ((PXW+1)'(pynyh6_reg) <<< NLO) + (PXW+1)'(pynyl6_reg);
            p2ap7_reg  <= p2ap6_reg;
            nxm7_reg   <= nxm6_reg;
            nym7_reg   <= nym6_reg;
            apm7_reg   <= apm6_reg;
            degen7_reg <= degen6_reg;
            nxneg7_reg <= nxneg6_reg;
            nyneg7_reg <= nyneg6_reg;
            apneg7_reg <= apneg6_reg;

            ax8_reg    <= ax7_reg;
            ay8_reg    <= ay7_reg;
            nx2_8_reg  <= (NSQ'(xhh7_reg) << (2*LO)) + (NSQ'(xlh7_reg) << (LO+1))
                          + NSQ'(xll7_reg);
            ny2_8_reg  <= (NSQ'(yhh7_reg) << (2*LO)) + (NSQ'(ylh7_reg) << (LO+1))
                          + NSQ'(yll7_reg);
            t8_reg     <= TW'(p2ap7_reg) - TW'(dot7_reg);
            apsq8_reg  <= apsq7_reg;
            nxm8_reg   <= nxm7_reg;
            nym8_reg   <= nym7_reg;
            apm8_reg   <= apm7_reg;
            degen8_reg <= degen7_reg;
            nxneg8_reg <= nxneg7_reg;
            nyneg8_reg <= nyneg7_reg;
            apneg8_reg <= apneg7_reg;
        end
    end

    // The point is inside when the determinant sign opposes the orientation.
    always_comb begin
        t8_le0 = t8_reg[TW-1] || (t8_reg == '0);
        t8_ge0 = !t8_reg[TW-1];
    end

    // Stage 9.
    always_ff @(posedge aclk) begin
        if (en) begin
            ax9_reg        <= ax8_reg;
            ay9_reg        <= ay8_reg;
            s9_reg         <= (NSQ+1)'(nx2_8_reg) + (NSQ+1)'(ny2_8_reg);
            apsq9_reg      <= apsq8_reg;
            nxm9_reg       <= nxm8_reg;
            nym9_reg       <= nym8_reg;
            apm9_reg       <= apm8_reg;
            degen9_reg     <= degen8_reg;
            in_circle9_reg <= !degen8_reg && (apneg8_reg ? t8_ge0 : t8_le0);
            cxneg9_reg     <= nxneg8_reg ^ apneg8_reg;
            cyneg9_reg     <= nyneg8_reg ^ apneg8_reg;
        end
    end

    // Dividend and divisor operands for the three quotients.
    always_comb begin
        flags_o.valid      = vld_reg[8];
        flags_o.degenerate = degen9_reg;
        flags_o.in_circle  = in_circle9_reg;
        flags_o.cx_neg     = cxneg9_reg;
        flags_o.cy_neg     = cyneg9_reg;
        ax_o     = ax9_reg;
        ay_o     = ay9_reg;
        num_cx_o = NCW'(nxm9_reg) << FRAC_BITS;
        num_cy_o = NCW'(nym9_reg) << FRAC_BITS;
        den_c_o  = {apm9_reg, 1'b0};
        num_r_o  = NRW'(s9_reg) << FRAC_BITS;
        den_r_o  = {apsq9_reg, 2'b00};
    end

endmodule

/* rtl/cpt_checker.sv */
// Port-level checker of the circumcircle point test and its bind.
`include "circumcircle_point_test_macros.svh"

module cpt_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [8*cpt_pkg::COORD_WIDTH_DEF-1:0] s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [cpt_pkg::OUT_TDATA_WIDTH-1:0] m_tdata
);

    logic unused_in;
    assign unused_in = s_tvalid ^ (^s_tdata);

    // A result that is not taken stays offered.
    `CPT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")

    // A stalled result keeps its contents.
    `CPT_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")

    // A collinear triangle reports nothing but the degenerate flag.
    `CPT_ASSERT_NOW(a_degen_zero, m_tvalid && m_tdata[121], m_tdata[120:0] == '0, "degenerate result carries data")

    // Leaving reset, the block is empty and ready for requests.
    `CPT_ASSERT_ALWAYS(a_reset_state, $past(!aresetn), s_tready && !m_tvalid, "state after reset")

endmodule

bind circumcircle_point_test cpt_checker u_cpt_checker (.*);

/* verif/testbench.sv */
// Self-checking testbench for the circumcircle point test block.
`timescale 1ns / 100ps

module testbench;

    localparam int CW          = 16;
    localparam int FRAC        = 8;
    localparam int LATENCY     = 68;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS_PER_PHASE = 175;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [CW-1:0] coord_t;

    // One triangle and query point, in port order.
    typedef struct {
        coord_t ax, ay, bx, by, cx, cy, px, py;
    } triangle_query_t;

    // One circumcircle result, field by field.
    typedef struct packed {
        logic [cpt_pkg::CENTER_WIDTH-1:0] center_x;
        logic [cpt_pkg::CENTER_WIDTH-1:0] center_y;
        logic [cpt_pkg::RAD_WIDTH-1:0]    radius_squared;
        logic                             inside_res;
        logic                             degenerate;
    } circle_result_t;

    // Directed request with an optional typed-in answer.
    typedef struct {
        triangle_query_t q;
        bit              typed;
        circle_result_t  answer;
    } directed_row_t;

    logic                                aclk;
    logic                                aresetn;
    logic                                s_tvalid;
    logic                                s_tready;
    logic [8*CW-1:0]                     s_tdata;
    logic                                m_tvalid;
    logic                                m_tready;
    logic [cpt_pkg::OUT_TDATA_WIDTH-1:0] m_tdata;

    circle_result_t pending_circles[$];
    int             sender_idle_pct;
    int             receiver_stall_pct;
    int             error_count = 0;
    int             results_seen = 0;
    int             cycle_count = 0;
    int             degenerate_seen = 0;
    int             inside_seen = 0;

    circumcircle_point_test u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Clock generation.
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Quotient rounded toward minus infinity.
    function automatic wide_t floor_div(input wide_t n, input wide_t d);
        wide_t q;
        q = n / d;
        if ((n % d != 0) && ((n < 0) != (d < 0))) begin
            q = q - 1;
        end
        return q;
    endfunction

    // Saturate a wide value into the signed 32-bit centre range.
    function automatic logic [cpt_pkg::CENTER_WIDTH-1:0] clamp_center(input wide_t v);
        if (v > wide_t'(64'sh7FFF_FFFF)) begin
            return cpt_pkg::CENTER_MAX;
        end
        if (v < -wide_t'(64'sh8000_0000)) begin
            return cpt_pkg::CENTER_MIN;
        end
        return v[cpt_pkg::CENTER_WIDTH-1:0];
    endfunction

    // Exact circumcircle of a triangle and the inside test for the query point.
    function automatic circle_result_t predict_circle(input triangle_query_t q);
        circle_result_t r;
        wide_t ox, oy, bx, by, cx, cy, px, py;
        wide_t area2, b2, c2, nx, ny, den, quo, test;
        wide_t rad_max;
        ox = wide_t'(q.ax);
        oy = wide_t'(q.ay);
        bx = wide_t'(q.bx) - ox;
        by = wide_t'(q.by) - oy;
        cx = wide_t'(q.cx) - ox;
        cy = wide_t'(q.cy) - oy;
        px = wide_t'(q.px) - ox;
        py = wide_t'(q.py) - oy;
        rad_max = (wide_t'(1) <<< cpt_pkg::RAD_WIDTH) - 1;
        r = '{default: '0};
        area2 = bx * cy - by * cx;
        if (area2 == 0) begin
            r.degenerate = 1'b1;
            return r;
        end
        b2  = bx * bx + by * by;
        c2  = cx * cx + cy * cy;
        nx  = cy * b2 - by * c2;
        ny  = bx * c2 - cx * b2;
        den = 2 * area2;
        r.center_x = clamp_center(floor_div((ox * den + nx) <<< FRAC, den));
        r.center_y = clamp_center(floor_div((oy * den + ny) <<< FRAC, den));
        quo = floor_div((nx * nx + ny * ny) <<< FRAC, den * den);
        r.radius_squared = (quo > rad_max) ? rad_max[cpt_pkg::RAD_WIDTH-1:0]
                                           : quo[cpt_pkg::RAD_WIDTH-1:0];
        // Orientation decides which sign of the test means inside.
        test = (px * px + py * py) * area2 - (px * nx + py * ny);
        r.inside_res = (area2 > 0) ? (test <= 0) : (test >= 0);
        return r;
    endfunction

    // Offer one request, with random idle cycles before it, until it is accepted.
    task automatic send_request(input triangle_query_t q);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {q.py, q.px, q.cy, q.cx, q.by, q.bx, q.ay, q.ax};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pending_circles.push_back(predict_circle(q));
    endtask

    // Directed request checked against a typed-in answer as well.
    task automatic send_directed(input directed_row_t row);
        circle_result_t p;
        p = predict_circle(row.q);
        if (row.typed && (p != row.answer)) begin
            $display("%0t: typed answer differs from prediction: exp %p got %p",
                     $time, row.answer, p);
            error_count++;
        end
        send_request(row.q);
    endtask

    // Random request: mostly full range, with collinear, small and on-circle cases.
    function automatic triangle_query_t random_query();
        triangle_query_t q;
        int kind;
        int k;
        kind = $urandom_range(9);
        q.ax = coord_t'($urandom); q.ay = coord_t'($urandom);
        q.bx = coord_t'($urandom); q.by = coord_t'($urandom);
        q.cx = coord_t'($urandom); q.cy = coord_t'($urandom);
        q.px = coord_t'($urandom); q.py = coord_t'($urandom);
        if (kind < 3) begin
            // Small triangle near a random origin, point close by.
            q.bx = q.ax + coord_t'($urandom_range(64) - 32);
            q.by = q.ay + coord_t'($urandom_range(64) - 32);
            q.cx = q.ax + coord_t'($urandom_range(64) - 32);
            q.cy = q.ay + coord_t'($urandom_range(64) - 32);
            q.px = q.ax + coord_t'($urandom_range(64) - 32);
            q.py = q.ay + coord_t'($urandom_range(64) - 32);
        end else if (kind == 3) begin
            // Collinear vertices.
            k = $urandom_range(6) - 3;
            q.ax = coord_t'($urandom_range(2000) - 1000);
            q.ay = coord_t'($urandom_range(2000) - 1000);
            q.bx = q.ax + coord_t'($urandom_range(200) - 100);
            q.by = q.ay + coord_t'($urandom_range(200) - 100);
            q.cx = q.ax + coord_t'(k) * (q.bx - q.ax);
            q.cy = q.ay + coord_t'(k) * (q.by - q.ay);
        end else if (kind == 4) begin
            // Query point on a vertex, so on the circle.
            case ($urandom_range(2))
                0: begin q.px = q.ax; q.py = q.ay; end
                1: begin q.px = q.bx; q.py = q.by; end
                default: begin q.px = q.cx; q.py = q.cy; end
            endcase
        end
        return q;
    endfunction

    // Result sink: random stalls and field-by-field comparison.
    always @(posedge aclk) begin
        circle_result_t got;
        circle_result_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
            if (m_tvalid && m_tready) begin
                got.center_x       = m_tdata[31:0];
                got.center_y       = m_tdata[63:32];
                got.radius_squared = m_tdata[119:64];
                got.inside_res     = m_tdata[120];
                got.degenerate     = m_tdata[121];
                results_seen++;
                if (pending_circles.size() == 0) begin
                    $display("%0t: result with none expected: got %p", $time, got);
                    error_count++;
                end else begin
                    exp_r = pending_circles.pop_front();
                    degenerate_seen += exp_r.degenerate;
                    inside_seen     += exp_r.inside_res;
                    if (got.center_x !== exp_r.center_x) begin
                        $display("%0t: center_x exp %h got %h", $time,
                                 exp_r.center_x, got.center_x);
                        error_count++;
                    end
                    if (got.center_y !== exp_r.center_y) begin
                        $display("%0t: center_y exp %h got %h", $time,
                                 exp_r.center_y, got.center_y);
                        error_count++;
                    end
                    if (got.radius_squared !== exp_r.radius_squared) begin
                        $display("%0t: radius_squared exp %h got %h", $time,
                                 exp_r.radius_squared, got.radius_squared);
                        error_count++;
                    end
                    if (got.inside_res !== exp_r.inside_res) begin
                        $display("%0t: inside_res exp %b got %b", $time,
                                 exp_r.inside_res, got.inside_res);
                        error_count++;
                    end
                    if (got.degenerate !== exp_r.degenerate) begin
                        $display("%0t: degenerate exp %b got %b", $time,
                                 exp_r.degenerate, got.degenerate);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Stimulus: directed table, then random phases with different idling.
    initial begin : stimulus
        directed_row_t rows[$];
        directed_row_t row;
        int phase;
        int n;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        aresetn            = 1'b0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Right triangle with centre (1,1) and r^2 = 2; point at the centre.
        row = '{q: '{0, 0, 2, 0, 0, 2, 1, 1}, typed: 1'b1,
                answer: '{32'd256, 32'd256, 56'd512, 1'b1, 1'b0}};
        rows.push_back(row);
        // Same circle, point far outside.
        row = '{q: '{0, 0, 2, 0, 0, 2, 5, 5}, typed: 1'b1,
                answer: '{32'd256, 32'd256, 56'd512, 1'b0, 1'b0}};
        rows.push_back(row);
        // Clockwise order, point on the circle.
        row = '{q: '{0, 0, 0, 2, 2, 0, 2, 2}, typed: 1'b1,
                answer: '{32'd256, 32'd256, 56'd512, 1'b1, 1'b0}};
        rows.push_back(row);
        // Collinear vertices and all-identical vertices.
        row = '{q: '{1, 1, 2, 2, 3, 3, 0, 0}, typed: 1'b1,
                answer: '{default: '0, degenerate: 1'b1}};
        rows.push_back(row);
        row = '{q: '{-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767},
                typed: 1'b1, answer: '{default: '0, degenerate: 1'b1}};
        rows.push_back(row);
        row = '{q: '{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768},
                typed: 1'b1, answer: '{default: '0, degenerate: 1'b1}};
        rows.push_back(row);
        // Extreme corners, nearly flat triangles that drive saturation, and smaller cases.
        row = '{q: '{-32768, -32768, 32767, -32768, -32768, 32767, 0, 0},
                typed: 1'b0, answer: '{default: '0}};
        rows.push_back(row);
        row = '{q: '{32767, 32767, -32768, 32767, 32767, -32768, -32768, -32768},
                typed: 1'b0, answer: '{default: '0}};
        rows.push_back(row);
        row = '{q: '{-32768, -32768, 32767, 32767, 32767, 32766, 0, 0},
                typed: 1'b0, answer: '{default: '0}};
        rows.push_back(row);
        row = '{q: '{-32768, 0, 32767, 0, 0, 1, 32767, -32768},
                typed: 1'b0, answer: '{default: '0}};
        rows.push_back(row);
        row = '{q: '{32767, -32768, -32768, 32767, -32767, 32767, 32767, 32767},
                typed: 1'b0, answer: '{default: '0}};
        rows.push_back(row);
        row = '{q: '{0, 0, 1, 0, 0, 1, -32768, 32767},
                typed: 1'b0, answer: '{default: '0}};
        rows.push_back(row);
        row = '{q: '{-1, -1, 0, -1, -1, 0, 0, 0},
                typed: 1'b0, answer: '{default: '0}};
        rows.push_back(row);
        row = '{q: '{100, 200, -300, 50, 20, -400, 100, 200},
                typed: 1'b0, answer: '{default: '0}};
        rows.push_back(row);
        foreach (rows[i]) begin
            send_directed(rows[i]);
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 50; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 50; end
                default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
            endcase
            for (n = 0; n < RANDOM_ITEMS_PER_PHASE; n++) begin
                send_request(random_query());
            end
            // Hold the sender until the pipeline has drained.
            s_tvalid <= 1'b0;
            while (pending_circles.size() != 0) begin
                @(posedge aclk);
            end
        end

        repeat (LATENCY + 32) @(posedge aclk);
        $display("Checked %0d circle results over four idling phases.", results_seen);
        $display("Of these %0d were collinear and %0d had the point inside.",
                 degenerate_seen, inside_seen);
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/cpt_pkg.sv
rtl/cpt_delay.sv
rtl/cpt_div.sv
rtl/cpt_front.sv
rtl/circumcircle_point_test.sv
rtl/cpt_checker.sv
verif/testbench.sv
